>>> design/ttb_pkg.sv
// Shared types and constants for the triangle tangent/bitangent block.
// No dependencies.
package ttb_pkg;
  localparam int POS_W = 24;
  localparam int TEX_W = 20;
  localparam int OUT_W = 32;
  localparam int DP_W  = POS_W + 1;            // position difference
  localparam int DT_W  = TEX_W + 1;            // texture difference
  localparam int DET_W = 2 * DT_W + 1;         // determinant
  localparam int NUM_W = DP_W + DT_W + 1;      // numerator

  typedef struct packed {
    logic signed [DP_W-1:0] dp1_x, dp1_y, dp1_z;
    logic signed [DP_W-1:0] dp2_x, dp2_y, dp2_z;
    logic signed [DT_W-1:0] du1, dv1, du2, dv2;
  } tri_diff_t;
endpackage

>>> design/triangle_tangent_bitangent.sv
// Top level of the triangle tangent/bitangent unit.
// Depends on ttb_pkg, ttb_front, ttb_queue, ttb_back.
//
// One corner per transaction on the in_ channel; every third corner closes a
// triangle and yields one out_ transaction with tangent and bitangent in
// Q16.16, saturated, rounded to nearest with ties away from zero, and a
// degenerate flag (zero vectors) when the texture determinant is zero. The
// first two corners of a triangle are taken one per cycle. The front end
// forms differences and pushes them into a two-entry queue; the back end
// takes a set, computes products, then numerators and the determinant,
// then the divider setup, then runs a single restoring divider over the
// six components, one quotient bit per cycle: 63 bits each at FRAC_BITS =
// 16 (46 numerator bits, 16 fraction bits and a round bit), each followed
// by a rounding step. A degenerate triangle skips the divider. The back end
// takes no new set until its result has been handed over. The divider sets
// the sustained rate.
module triangle_tangent_bitangent #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_z,
  input  logic signed [ttb_pkg::TEX_W-1:0] in_tex_u,
  input  logic signed [ttb_pkg::TEX_W-1:0] in_tex_v,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ttb_pkg::OUT_W-1:0] out_tangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0] out_tangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0] out_tangent_z,
  output logic signed [ttb_pkg::OUT_W-1:0] out_bitangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0] out_bitangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0] out_bitangent_z,
  output logic                             out_degenerate
);
  import ttb_pkg::*;

  logic qw_valid, qw_ready, qr_valid, qr_ready;
  tri_diff_t qw_data, qr_data;

  ttb_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_tex_u, .in_tex_v,
    .q_valid(qw_valid), .q_ready(qw_ready), .q_data(qw_data)
  );

  ttb_queue u_queue (
    .clk, .rst_n,
    .wr_valid(qw_valid), .wr_ready(qw_ready), .wr_data(qw_data),
    .rd_valid(qr_valid), .rd_ready(qr_ready), .rd_data(qr_data)
  );

  ttb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n,
    .d_valid(qr_valid), .d_ready(qr_ready), .d_data(qr_data),
    .out_valid, .out_ready, .out_tangent_x, .out_tangent_y, .out_tangent_z,
    .out_bitangent_x, .out_bitangent_y, .out_bitangent_z, .out_degenerate
  );
endmodule

>>> design/ttb_front.sv
// Front end: holds the first two corners and emits difference sets.
// Depends on ttb_pkg.
module ttb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_z,
  input  logic signed [ttb_pkg::TEX_W-1:0] in_tex_u,
  input  logic signed [ttb_pkg::TEX_W-1:0] in_tex_v,
  output logic                            q_valid,
  input  logic                            q_ready,
  output ttb_pkg::tri_diff_t              q_data
);
  import ttb_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  logic signed [POS_W-1:0] px_r [2], py_r [2], pz_r [2];
  logic signed [TEX_W-1:0] tu_r [2], tv_r [2];
  logic acc, third;

  // a third corner waits until the queue has room
  assign third    = (cnt_r == 2'd2);
  assign in_ready = !third || q_ready;
  assign acc      = in_valid && in_ready;
  assign q_valid  = in_valid && third;

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) cnt_nxt = third ? 2'd0 : cnt_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && !third) begin
      px_r[cnt_r[0]] <= in_pos_x;
      py_r[cnt_r[0]] <= in_pos_y;
      pz_r[cnt_r[0]] <= in_pos_z;
      tu_r[cnt_r[0]] <= in_tex_u;
      tv_r[cnt_r[0]] <= in_tex_v;
    end
  end

  always_comb begin
    q_data.dp1_x = DP_W'(px_r[1]) - DP_W'(px_r[0]);
    q_data.dp1_y = DP_W'(py_r[1]) - DP_W'(py_r[0]);
    q_data.dp1_z = DP_W'(pz_r[1]) - DP_W'(pz_r[0]);
    q_data.dp2_x = DP_W'(in_pos_x) - DP_W'(px_r[0]);
    q_data.dp2_y = DP_W'(in_pos_y) - DP_W'(py_r[0]);
    q_data.dp2_z = DP_W'(in_pos_z) - DP_W'(pz_r[0]);
    q_data.du1   = DT_W'(tu_r[1]) - DT_W'(tu_r[0]);
    q_data.dv1   = DT_W'(tv_r[1]) - DT_W'(tv_r[0]);
    q_data.du2   = DT_W'(in_tex_u) - DT_W'(tu_r[0]);
    q_data.dv2   = DT_W'(in_tex_v) - DT_W'(tv_r[0]);
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("corner count out of range");
  a_third_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    acc && third |=> cnt_r == 2'd0) else $error("count did not wrap");
  a_push_third: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |-> third) else $error("push without third corner");
`endif
endmodule

>>> design/ttb_queue.sv
// Two-entry queue of difference sets between front and back ends.
// Depends on ttb_pkg.
module ttb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  ttb_pkg::tri_diff_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output ttb_pkg::tri_diff_t rd_data
);
  import ttb_pkg::*;

  tri_diff_t mem_r [2];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] n_r, n_nxt;
  logic wr, rd;

  assign wr_ready = (n_r != 2'd2);
  assign rd_valid = (n_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_comb begin
    wp_nxt = wr ? !wp_r : wp_r;
    rp_nxt = rd ? !rp_r : rp_r;
    n_nxt  = n_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_fill: assert property (@(posedge clk) disable iff (!rst_n) n_r <= 2'd2)
    else $error("queue overfilled");
  a_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (n_r == 2'd0 || n_r == 2'd2) |-> wp_r == rp_r) else $error("pointer mismatch");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    n_r == 2'd1 |-> wp_r != rp_r) else $error("pointer mismatch");
`endif
endmodule

>>> design/ttb_back.sv
// Back end: determinant, six numerators and a shared restoring divider.
// Depends on ttb_pkg.
module ttb_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             d_valid,
  output logic                             d_ready,
  input  ttb_pkg::tri_diff_t               d_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ttb_pkg::OUT_W-1:0] out_tangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0] out_tangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0] out_tangent_z,
  output logic signed [ttb_pkg::OUT_W-1:0] out_bitangent_x,
  output logic signed [ttb_pkg::OUT_W-1:0] out_bitangent_y,
  output logic signed [ttb_pkg::OUT_W-1:0] out_bitangent_z,
  output logic                             out_degenerate
);
  import ttb_pkg::*;
  parameter int FRAC_BITS = 16;

  localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_NUM = 3'd2, S_SETUP = 3'd3,
                         S_DIV = 3'd4, S_RND = 3'd5, S_OUT = 3'd6;
  localparam int PW  = DP_W + DT_W;            // product
  localparam int MW  = NUM_W - 1;              // numerator magnitude
  localparam int DW  = DET_W - 1;              // det magnitude
  localparam int QW  = MW + FRAC_BITS + 1;     // quotient incl. round bit
  localparam int RW  = DW + 1;
  localparam int SW  = $clog2(QW + 1);

  logic [2:0] st_r, st_nxt;
  tri_diff_t d_r;
  logic signed [PW-1:0]    pa_r [6], pb_r [6];
  logic signed [2*DT_W-1:0] ma_r, mb_r;
  logic signed [NUM_W-1:0] num_r [6];
  logic signed [DET_W-1:0] det_r;
  logic [2:0] idx_r;
  logic [SW-1:0] step_r;
  logic [QW-1:0] q_r;
  logic [RW-1:0] rem_r;
  logic [MW-1:0] un_r;
  logic [DW-1:0] ud;
  logic neg_r;
  logic signed [OUT_W-1:0] res_r [6];
  logic degen_r;
  logic [RW-1:0] rem_sh;
  logic [QW-2:0] qmag;
  logic [QW-1:0] qrnd, lim;
  logic signed [OUT_W-1:0] res_v;
  logic signed [NUM_W-1:0] cur;
  logic [2:0] idx_inc;
  logic signed [NUM_W-1:0] nxt_num;

  assign d_ready   = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign ud  = det_r[DET_W-1] ? DW'(-det_r) : DW'(det_r);
  assign cur = num_r[idx_r];
  assign rem_sh = {rem_r[RW-2:0], un_r[MW-1]};
  // next lane; wraps after the last so the read stays in range
  assign idx_inc = (idx_r == 3'd5) ? 3'd0 : idx_r + 3'd1;
  assign nxt_num = num_r[idx_inc];

  always_comb begin
    // quotient register holds the value times two; bit 0 is the round bit
    qmag = q_r[QW-1:1] + (QW-1)'(q_r[0]);
    lim  = neg_r ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
    qrnd = {1'b0, qmag};
    if (qrnd > lim) qrnd = lim;
    res_v = neg_r ? -OUT_W'(qrnd) : OUT_W'(qrnd);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (d_valid) st_nxt = S_MUL;
      S_MUL:   st_nxt = S_NUM;
      S_NUM:   st_nxt = S_SETUP;
      S_SETUP: st_nxt = (det_r == '0) ? S_OUT : S_DIV;
      S_DIV:   if (step_r == SW'(QW - 1)) st_nxt = S_RND;
      S_RND:   st_nxt = (idx_r == 3'd5) ? S_OUT : S_DIV;
      S_OUT:   if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (d_valid) d_r <= d_data;
      S_MUL: begin
        pa_r[0] <= d_r.dp1_x * d_r.dv2;  pb_r[0] <= d_r.dp2_x * d_r.dv1;
        pa_r[1] <= d_r.dp1_y * d_r.dv2;  pb_r[1] <= d_r.dp2_y * d_r.dv1;
        pa_r[2] <= d_r.dp1_z * d_r.dv2;  pb_r[2] <= d_r.dp2_z * d_r.dv1;
        pa_r[3] <= d_r.dp2_x * d_r.du1;  pb_r[3] <= d_r.dp1_x * d_r.du2;
        pa_r[4] <= d_r.dp2_y * d_r.du1;  pb_r[4] <= d_r.dp1_y * d_r.du2;
        pa_r[5] <= d_r.dp2_z * d_r.du1;  pb_r[5] <= d_r.dp1_z * d_r.du2;
        ma_r <= d_r.du1 * d_r.dv2;
        mb_r <= d_r.dv1 * d_r.du2;
      end
      S_NUM: begin
        for (int k = 0; k < 6; k++) num_r[k] <= NUM_W'(pa_r[k]) - NUM_W'(pb_r[k]);
        det_r <= DET_W'(ma_r) - DET_W'(mb_r);
        idx_r <= 3'd0;
      end
      S_SETUP: begin
        degen_r <= (det_r == '0);
        step_r  <= '0;
        q_r     <= '0;
        rem_r   <= '0;
        un_r    <= cur[NUM_W-1] ? MW'(-cur) : MW'(cur);
        neg_r   <= cur[NUM_W-1] != det_r[DET_W-1];
        if (det_r == '0) for (int k = 0; k < 6; k++) res_r[k] <= '0;
      end
      S_DIV: begin
        // one quotient bit a cycle; numerator bits then zeros shift in
        step_r <= step_r + SW'(1);
        un_r   <= un_r << 1;
        if (rem_sh >= RW'(ud)) begin
          rem_r <= rem_sh - RW'(ud);
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
      end
      S_RND: begin
        res_r[idx_r] <= res_v;
        idx_r  <= idx_r + 3'd1;
        step_r <= '0;
        q_r    <= '0;
        rem_r  <= '0;
        un_r   <= nxt_num[NUM_W-1] ? MW'(-nxt_num) : MW'(nxt_num);
        neg_r  <= nxt_num[NUM_W-1] != det_r[DET_W-1];
      end
      default: ;
    endcase
  end

  assign out_tangent_x   = res_r[0];
  assign out_tangent_y   = res_r[1];
  assign out_tangent_z   = res_r[2];
  assign out_bitangent_x = res_r[3];
  assign out_bitangent_y = res_r[4];
  assign out_bitangent_z = res_r[5];
  assign out_degenerate  = degen_r;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_rem: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> rem_r < RW'(ud)) else $error("remainder not reduced");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DIV |-> idx_r <= 3'd5) else $error("lane index overrun");
`endif
endmodule

>>> tb/triangle_tangent_bitangent_test.sv
`timescale 1ns / 1ps
// Self-checking test of triangle_tangent_bitangent: streams triangle corners and checks
// each tangent/bitangent transaction against a behavioural predictor held here.
// Depends on ttb_pkg and the block's RTL.
module triangle_tangent_bitangent_test;
  import ttb_pkg::*;

  localparam int FRAC_BITS = 16;

  // idling modes for the two sides
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] tx, ty, tz, bx, by, bz;
    logic                    degen;
  } tangent_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [TEX_W-1:0] in_tex_u = '0, in_tex_v = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [OUT_W-1:0] out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic out_degenerate;

  triangle_tangent_bitangent #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  idle_mode_t idle_mode = IDLE_NONE;
  int errors = 0;
  tangent_frame_t expected_frames[$];

  // predictor state: the two held corners of the open triangle
  logic signed [POS_W-1:0] held_pos[6];
  logic signed [TEX_W-1:0] held_tex[4];
  int corners_seen = 0;

  // numerator * 2^FRAC_BITS / det, nearest with ties away from zero, saturated
  function automatic logic signed [OUT_W-1:0] scaled_quotient(longint num, longint den);
    logic neg;
    logic [127:0] un, ud, q, r, mag, lim;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    un = un << FRAC_BITS;
    q = un / ud;
    r = un % ud;
    if (2 * r >= ud) q = q + 1;
    mag = q > lim ? lim : q;
    return neg ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
  endfunction

  // advance the predictor by one corner; queues a frame on every third
  task automatic predict_corner(logic signed [POS_W-1:0] px, py, pz,
                                logic signed [TEX_W-1:0] tu, tv);
    longint p[3], dp1[3], dp2[3], du1, dv1, du2, dv2, det;
    tangent_frame_t f;
    p[0] = px; p[1] = py; p[2] = pz;
    if (corners_seen < 2) begin
      for (int k = 0; k < 3; k++) held_pos[corners_seen*3+k] = POS_W'(p[k]);
      held_tex[corners_seen*2] = tu;
      held_tex[corners_seen*2+1] = tv;
      corners_seen++;
      return;
    end
    corners_seen = 0;
    for (int k = 0; k < 3; k++) begin
      dp1[k] = longint'(held_pos[3+k]) - longint'(held_pos[k]);
      dp2[k] = p[k] - longint'(held_pos[k]);
    end
    du1 = longint'(held_tex[2]) - held_tex[0];
    dv1 = longint'(held_tex[3]) - held_tex[1];
    du2 = longint'(tu) - held_tex[0];
    dv2 = longint'(tv) - held_tex[1];
    det = du1 * dv2 - dv1 * du2;
    f = '0;
    if (det == 0) f.degen = 1'b1;
    else begin
      f.tx = scaled_quotient(dp1[0]*dv2 - dp2[0]*dv1, det);
      f.ty = scaled_quotient(dp1[1]*dv2 - dp2[1]*dv1, det);
      f.tz = scaled_quotient(dp1[2]*dv2 - dp2[2]*dv1, det);
      f.bx = scaled_quotient(dp2[0]*du1 - dp1[0]*du2, det);
      f.by = scaled_quotient(dp2[1]*du1 - dp1[1]*du2, det);
      f.bz = scaled_quotient(dp2[2]*du1 - dp1[2]*du2, det);
    end
    expected_frames.insert(expected_frames.size(), f);
  endtask

  // one corner transaction; sender gaps drawn before valid goes up,
  // valid only drops during a gap or when the stream stops
  task automatic send_corner(logic signed [POS_W-1:0] px, py, pz,
                             logic signed [TEX_W-1:0] tu, tv);
    if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)
      while ($urandom_range(99) < 71) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_tex_u <= tu; in_tex_v <= tv;
    do @(posedge clk); while (!in_ready);
    predict_corner(px, py, pz, tu, tv);
  endtask

  // receiver: random stalls in the receive-idling modes, else always ready; drives out_ready once per edge
  always @(posedge clk) begin
    if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH)
      out_ready <= ($urandom_range(99) >= 71);
    else
      out_ready <= 1'b1;
  end

  // checker: compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tangent_frame_t got, want;
      got = {out_tangent_x, out_tangent_y, out_tangent_z,
             out_bitangent_x, out_bitangent_y, out_bitangent_z, out_degenerate};
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $time, got);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        if (got.tx !== want.tx) begin
          $display("%0t: tangent_x exp %h got %h", $time, want.tx, got.tx); errors++; end
        if (got.ty !== want.ty) begin
          $display("%0t: tangent_y exp %h got %h", $time, want.ty, got.ty); errors++; end
        if (got.tz !== want.tz) begin
          $display("%0t: tangent_z exp %h got %h", $time, want.tz, got.tz); errors++; end
        if (got.bx !== want.bx) begin
          $display("%0t: bitangent_x exp %h got %h", $time, want.bx, got.bx); errors++; end
        if (got.by !== want.by) begin
          $display("%0t: bitangent_y exp %h got %h", $time, want.by, got.by); errors++; end
        if (got.bz !== want.bz) begin
          $display("%0t: bitangent_z exp %h got %h", $time, want.bz, got.bz); errors++; end
        if (got.degen !== want.degen) begin
          $display("%0t: degenerate exp %b got %b", $time, want.degen, got.degen);
          errors++;
        end
      end
    end
  end

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // random corner, full-range or restricted to small values
  task automatic send_random_corner(bit full_range);
    logic signed [POS_W-1:0] p[3];
    logic signed [TEX_W-1:0] t[2];
    for (int k = 0; k < 3; k++)
      p[k] = full_range ? POS_W'($urandom) : POS_W'($signed($urandom_range(8191)) - 4096);
    for (int k = 0; k < 2; k++)
      t[k] = full_range ? TEX_W'($urandom) : TEX_W'($signed($urandom_range(131071)) - 65536);
    send_corner(p[0], p[1], p[2], t[0], t[1]);
  endtask

  // extremes, degenerate and saturating triangles
  task automatic test_directed();
    localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [TEX_W-1:0] TMAX = {1'b0, {(TEX_W-1){1'b1}}};
    localparam logic signed [TEX_W-1:0] TMIN = {1'b1, {(TEX_W-1){1'b0}}};
    idle_mode = IDLE_NONE;
    // plain unit triangle
    send_corner(0, 0, 0, 0, 0);
    send_corner(24'h10000, 0, 0, 20'h10000, 0);
    send_corner(0, 24'h10000, 0, 0, 20'h10000);
    // zero determinant: all texcoords equal
    send_corner(PMAX, PMIN, 5, 7, 7);
    send_corner(PMIN, PMAX, -5, 7, 7);
    send_corner(1, 2, 3, 7, 7);
    // tiny determinant with huge positions: saturation both ways
    send_corner(PMIN, PMIN, PMAX, 0, 0);
    send_corner(PMAX, PMAX, PMIN, 1, 0);
    send_corner(PMIN, PMAX, PMIN, 0, 1);
    // texture extremes
    send_corner(PMAX, PMAX, PMAX, TMIN, TMIN);
    send_corner(PMIN, PMIN, PMIN, TMAX, TMIN);
    send_corner(PMAX, PMIN, 0, TMIN, TMAX);
    // det 2, odd tangent numerators, zero bitangent numerators
    send_corner(0, 0, 0, 0, 0);
    send_corner(24'sd1, -24'sd1, 24'sd3, 20'sd2, 0);
    send_corner(0, 0, 0, 0, 20'sd1);
    // corners built from -1 and 0, positive det
    send_corner(-1, -1, -1, -1, -1);
    send_corner(0, 0, 0, 0, -1);
    send_corner(-1, 0, -1, -1, 0);
    drain_results();
  endtask

  task automatic test_random(idle_mode_t mode, int corners);
    idle_mode = mode;
    for (int i = 0; i < corners; i++) begin
      // occasional collinear texcoords to hit degeneracy mid-stream
      if ($urandom_range(19) == 0) send_corner(POS_W'($urandom), POS_W'($urandom),
                                               POS_W'($urandom), 20'sd5, 20'sd5);
      else send_random_corner($urandom_range(3) == 0);
    end
  endtask

  // sender holds off until the block has emptied, then resumes
  task automatic test_pause_until_empty();
    idle_mode = IDLE_NONE;
    repeat (6) send_random_corner(1'b0);
    drain_results();
    repeat (6) send_random_corner(1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(IDLE_NONE, 480);
    test_random(IDLE_SEND, 480);
    test_pause_until_empty();
    test_random(IDLE_RECV, 480);
    test_random(IDLE_BOTH, 459);
    drain_results();
    repeat (500) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // watchdog: ~640 triangles under stalls, with a wide margin
  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule

>>> files.f
design/ttb_pkg.sv
design/ttb_front.sv
design/ttb_queue.sv
design/ttb_back.sv
design/triangle_tangent_bitangent.sv
tb/triangle_tangent_bitangent_test.sv
